FILE: design/cdcsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcsw_pkg
// field widths and calendar lookup tables for the date check block
// ----------------------------------------------------------------------------
package cdcsw_pkg;

   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int YEAR_W   = 14;
   localparam int SERIAL_W = 22;
   localparam int WDAY_W   = 3;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // reciprocal of 100 for years below 2^14: q = (y * 5243) >> 19
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_PW    = YEAR_W + 13;

   function automatic logic [2:0] month_code(input logic [MONTH_W-1:0] m);
      logic [2:0] c;
      unique case (m)
         4'd1:    c = 3'd0;
         4'd2:    c = 3'd3;
         4'd3:    c = 3'd3;
         4'd4:    c = 3'd6;
         4'd5:    c = 3'd1;
         4'd6:    c = 3'd4;
         4'd7:    c = 3'd6;
         4'd8:    c = 3'd2;
         4'd9:    c = 3'd5;
         4'd10:   c = 3'd0;
         4'd11:   c = 3'd3;
         4'd12:   c = 3'd5;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] century_code(input logic [1:0] c);
      logic [2:0] v;
      unique case (c)
         2'd0:    v = 3'd6;
         2'd1:    v = 3'd4;
         2'd2:    v = 3'd2;
         default: v = 3'd0;
      endcase
      return v;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] n;
      unique case (m)
         4'd2:    n = 5'd28;
         4'd4:    n = 5'd30;
         4'd6:    n = 5'd30;
         4'd9:    n = 5'd30;
         4'd11:   n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      unique case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // 8 is 1 mod 7, so fold octal digits twice and correct once
   function automatic logic [2:0] mod7(input logic [6:0] v);
      logic [4:0] s1;
      logic [3:0] s2;
      logic [3:0] s3;
      s1 = {1'b0, v[6:3]} + {2'b00, v[2:0]};
      s2 = {2'b00, s1[4:3]} + {1'b0, s1[2:0]};
      s3 = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
      return s3[2:0];
   endfunction

endpackage

FILE: design/calendar_date_check_serial_weekday.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_check_serial_weekday
// checks a gregorian date and returns its day serial and weekday
// ----------------------------------------------------------------------------
// channel  dir  ports                                   meaning
// req      in   req_valid req_stall req_month/day/year  one date
// rsp      out  rsp_valid rsp_stall rsp_valid_res
//                rsp_day_serial rsp_week_day            check, serial, weekday
//
// four register stages: divide by 100, leap and range check, multiply by
// 365 and weekday parts, final sums; one word a cycle while the output is not stalled
// reset clears the stage valid bits only
// a stalled stage holds, and empty stages ahead of it still fill
// ----------------------------------------------------------------------------
module calendar_date_check_serial_weekday
   import cdcsw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MONTH_W-1:0]  req_month,
   input  logic [DAY_W-1:0]    req_day,
   input  logic [YEAR_W-1:0]   req_year,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_valid_res,
   output logic [SERIAL_W-1:0] rsp_day_serial,
   output logic [WDAY_W-1:0]   rsp_week_day
);

   logic en1, en2, en3, en4;

   // stage 1
   logic                v1_ff;
   logic [MONTH_W-1:0]  m1_ff;
   logic [DAY_W-1:0]    d1_ff;
   logic [YEAR_W-1:0]   y1_ff;
   logic [7:0]          q1_ff;
   logic [DIV100_PW-1:0] q_prod;
   logic [7:0]          q1_in;

   // stage 2
   logic                v2_ff;
   logic [MONTH_W-1:0]  m2_ff;
   logic [DAY_W-1:0]    d2_ff;
   logic [YEAR_W-1:0]   y2_ff;
   logic [6:0]          r2_ff;
   logic [1:0]          c2_ff;
   logic                leap2_ff;
   logic                ok2_ff;
   logic [12:0]         leaps2_ff;
   logic [YEAR_W-1:0]   hund;
   logic [YEAR_W-1:0]   r_full;
   logic [6:0]          r2_in;
   logic                leap2_in;
   logic                ok2_in;
   logic [DAY_W-1:0]    lim;
   logic [8:0]          c100;
   logic [8:0]          c100p3;
   logic [6:0]          c400;
   logic [YEAR_W:0]     yp3;
   logic [12:0]         c4;
   logic [12:0]         leaps2_in;

   // stage 3
   logic                v3_ff;
   logic                ok3_ff;
   logic [SERIAL_W-1:0] y365_ff;
   logic [12:0]         leaps3_ff;
   logic [8:0]          base3_ff;
   logic [2:0]          yc3_ff;
   logic [3:0]          mcc3_ff;
   logic [DAY_W-1:0]    d3_ff;
   logic                lyc3_ff;
   logic [YEAR_W+8:0]   y365_full;
   logic [8:0]          base3_in;
   logic [6:0]          ysum;
   logic [3:0]          mcc3_in;

   // stage 4
   logic                v4_ff;
   logic                ok4_ff;
   logic [SERIAL_W-1:0] serial4_ff;
   logic [WDAY_W-1:0]   wd4_ff;
   logic [SERIAL_W-1:0] serial4_in;
   logic [5:0]          wsum;
   logic [WDAY_W-1:0]   wd4_in;

   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: year / 100
   assign q_prod = DIV100_PW'(req_year) * DIV100_PW'(DIV100_MUL);
   assign q1_in  = q_prod[DIV100_SHIFT+7:DIV100_SHIFT];

   always_ff @(posedge clock) begin
      if (en1) begin
         m1_ff <= req_month;
         d1_ff <= req_day;
         y1_ff <= req_year;
         q1_ff <= q1_in;
      end
   end

   // stage 2: year % 100, leap, range check, leap days before the year
   assign hund     = YEAR_W'(q1_ff) * YEAR_W'(100);
   assign r_full   = y1_ff - hund;
   assign r2_in    = r_full[6:0];
   assign leap2_in = (y1_ff[1:0] == 2'b00) && ((r2_in != 7'd0) || (q1_ff[1:0] == 2'b00));
   assign lim      = (m1_ff == MONTH_FEB && leap2_in) ? 5'd29 : month_len(m1_ff);
   assign ok2_in   = (m1_ff >= MONTH_JAN) && (m1_ff <= MONTH_DEC) &&
                     (d1_ff != '0) && (d1_ff <= lim);
   assign c100     = {1'b0, q1_ff} + {8'd0, (r2_in != 7'd0)};
   assign c100p3   = c100 + 9'd3;
   assign c400     = c100p3[8:2];
   assign yp3      = {1'b0, y1_ff} + (YEAR_W+1)'(3);
   assign c4       = yp3[YEAR_W:2];
   assign leaps2_in = c4 - {4'd0, c100} + {6'd0, c400};

   always_ff @(posedge clock) begin
      if (en2) begin
         m2_ff     <= m1_ff;
         d2_ff     <= d1_ff;
         y2_ff     <= y1_ff;
         r2_ff     <= r2_in;
         c2_ff     <= q1_ff[1:0];
         leap2_ff  <= leap2_in;
         ok2_ff    <= ok2_in;
         leaps2_ff <= leaps2_in;
      end
   end

   // stage 3: days of whole years, days before month, weekday parts
   assign y365_full = (YEAR_W+9)'(y2_ff) * (YEAR_W+9)'(365);
   assign base3_in  = days_before(m2_ff) + {4'd0, d2_ff} +
                      {8'd0, (leap2_ff && m2_ff > MONTH_FEB)};
   assign ysum      = r2_ff + {2'b00, r2_ff[6:2]};
   assign mcc3_in   = {1'b0, month_code(m2_ff)} + {1'b0, century_code(c2_ff)};

   always_ff @(posedge clock) begin
      if (en3) begin
         ok3_ff    <= ok2_ff;
         y365_ff   <= y365_full[SERIAL_W-1:0];
         leaps3_ff <= leaps2_ff;
         base3_ff  <= base3_in;
         yc3_ff    <= mod7(ysum);
         mcc3_ff   <= mcc3_in;
         d3_ff     <= d2_ff;
         lyc3_ff   <= leap2_ff && (m2_ff <= MONTH_FEB);
      end
   end

   // stage 4: final sums, zero for a bad date
   assign serial4_in = y365_ff + SERIAL_W'(leaps3_ff) + SERIAL_W'(base3_ff);
   assign wsum       = {3'd0, yc3_ff} + {2'd0, mcc3_ff} + {1'b0, d3_ff} + 6'd6 -
                       {5'd0, lyc3_ff};
   assign wd4_in     = mod7({1'b0, wsum});

   always_ff @(posedge clock) begin
      if (en4) begin
         ok4_ff     <= ok3_ff;
         serial4_ff <= ok3_ff ? serial4_in : '0;
         wd4_ff     <= ok3_ff ? wd4_in : '0;
      end
   end

   assign rsp_valid      = v4_ff;
   assign rsp_valid_res  = ok4_ff;
   assign rsp_day_serial = serial4_ff;
   assign rsp_week_day   = wd4_ff;

endmodule

FILE: design/cdcsw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcsw_checker
// port level checks for the date check block, bound to the top level
// ----------------------------------------------------------------------------
module cdcsw_checker
   import cdcsw_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_valid_res,
   input logic [SERIAL_W-1:0] rsp_day_serial,
   input logic [WDAY_W-1:0]   rsp_week_day
);

   // bad date gives zero serial and weekday
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_day_serial == '0 && rsp_week_day == '0)
      else $error("bad date word carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_week_day <= WDAY_W'(6))
      else $error("weekday out of range");

   // empty output register never holds back the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_day_serial) &&
      $stable(rsp_week_day) && $stable(rsp_valid_res))
      else $error("stalled word changed");

endmodule

bind calendar_date_check_serial_weekday cdcsw_checker u_cdcsw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_valid_res  (rsp_valid_res),
   .rsp_day_serial (rsp_day_serial),
   .rsp_week_day   (rsp_week_day)
);
